// ===== sv/ymodem_packet_framer_defines.svh =====
// ----------------------------------------------------------------------------
// YMODEM packet framer assertion macros
// Concurrent check wrappers, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef YMODEM_PACKET_FRAMER_DEFINES_SVH
`define YMODEM_PACKET_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define YMPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ympf check failed");
`define YMPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ympf check failed");
`else
`define YMPF_ASSERT_SAME(label, clk, rst, ante, cons)
`define YMPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/ympf_pkg.sv =====
// ----------------------------------------------------------------------------
// YMODEM packet framer package
// Operation codes, framing constants, result type and CRC-16 byte fold.
// ----------------------------------------------------------------------------
`default_nettype none

package ympf_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_START = 2'd0;
   localparam op_type OP_DATA  = 2'd1;
   localparam op_type OP_PULL  = 2'd2;

   localparam logic [7:0]  CHAR_SOH      = 8'h01;
   localparam logic [7:0]  CHAR_STX      = 8'h02;
   localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_MSB       = 16'h8000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       end_of_packet;
   } result_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ympf_channels.sv =====
// ----------------------------------------------------------------------------
// YMODEM packet framer channels
// Valid/ready request and response interfaces with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ympf_req_if;
   logic             valid;
   logic             ready;
   ympf_pkg::op_type operation;
   logic [7:0]       data_byte;
   logic [7:0]       block_number;
   logic             large_packet;
   logic [7:0]       pad_byte;

   modport source (output valid, output operation, output data_byte,
                   output block_number, output large_packet, output pad_byte,
                   input ready);
   modport sink   (input valid, input operation, input data_byte,
                   input block_number, input large_packet, input pad_byte,
                   output ready);
endinterface

interface ympf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       end_of_packet;

   modport source (output valid, output packet_byte, output end_of_packet, input ready);
   modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// ===== sv/ymodem_packet_framer.sv =====
// Accepted results are registered into the result queue and offered on rsp in order.
// Throughput: one data or pull transaction per cycle while req is ready, one result byte
// per cycle while rsp is ready; a start transaction yields three header bytes together.
// req stalls while the four-entry result queue lacks room for three results.
// Reset (synchronous, active high) returns the framer to idle and empties the queue.
// ----------------------------------------------------------------------------
// YMODEM packet framer
// Emits header, payload with padding and CRC-16 trailer of one YMODEM packet.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ymodem_packet_framer_defines.svh"

module ymodem_packet_framer #(
   parameter int SMALL_PAYLOAD = 128,
   parameter int LARGE_PAYLOAD = 1024
) (
   input  wire            clock,
   input  wire            reset,
   ympf_req_if.sink       req,
   ympf_rsp_if.source     rsp
);

   localparam int MAX_PAYLOAD = (SMALL_PAYLOAD > LARGE_PAYLOAD) ? SMALL_PAYLOAD : LARGE_PAYLOAD;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] SMALL_SIZE = CNT_W'(SMALL_PAYLOAD);
   localparam logic [CNT_W-1:0] LARGE_SIZE = CNT_W'(LARGE_PAYLOAD);

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
   localparam logic [1:0] PHASE_CRC_LOW = 2'd2;

   localparam logic [ympf_pkg::QCNT_W-1:0] ROOM_LIMIT =
      ympf_pkg::QCNT_W'(ympf_pkg::QUEUE_DEPTH - 3);
   localparam logic [ympf_pkg::QCNT_W-1:0] DEPTH_LIMIT =
      ympf_pkg::QCNT_W'(ympf_pkg::QUEUE_DEPTH);

   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       phase_ff, phase_in;
   logic             large_ff, large_in;
   logic [7:0]       fill_ff, fill_in;

   ympf_pkg::result_type            queue_ff [ympf_pkg::QUEUE_DEPTH];
   logic [ympf_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [ympf_pkg::QCNT_W-1:0]     qcount_ff, qcount_in;

   ympf_pkg::result_type lane [3];
   logic [1:0]           push_n;
   logic                 accept, pop, full;
   logic [CNT_W-1:0]     cur_size;

   assign req.ready = (qcount_ff <= ROOM_LIMIT);
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;
   assign cur_size  = large_ff ? LARGE_SIZE : SMALL_SIZE;
   assign full      = (count_ff >= cur_size);

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      large_in = large_ff;
      fill_in  = fill_ff;
      push_n   = 2'd0;
      for (int k = 0; k < 3; k++) begin
         lane[k] = '0;
      end
      if (accept) begin
         case (req.operation)
            ympf_pkg::OP_START: begin
               large_in = req.large_packet;
               fill_in  = req.pad_byte;
               crc_in   = 16'h0000;
               count_in = '0;
               phase_in = PHASE_PAYLOAD;
               lane[0].packet_byte = req.large_packet ? ympf_pkg::CHAR_STX : ympf_pkg::CHAR_SOH;
               lane[1].packet_byte = req.block_number;
               lane[2].packet_byte = ympf_pkg::BYTE_ALL_ONES - req.block_number;
               push_n = 2'd3;
            end
            ympf_pkg::OP_DATA: begin
               if (phase_ff == PHASE_PAYLOAD && !full) begin
                  crc_in   = ympf_pkg::crc_fold(crc_ff, req.data_byte);
                  count_in = count_ff + CNT_W'(1);
                  lane[0].packet_byte = req.data_byte;
                  push_n = 2'd1;
               end
            end
            ympf_pkg::OP_PULL: begin
               if (phase_ff == PHASE_PAYLOAD) begin
                  if (!full) begin
                     crc_in   = ympf_pkg::crc_fold(crc_ff, fill_ff);
                     count_in = count_ff + CNT_W'(1);
                     lane[0].packet_byte = fill_ff;
                  end else begin
                     phase_in = PHASE_CRC_LOW;
                     lane[0].packet_byte = crc_ff[15:8];
                  end
                  push_n = 2'd1;
               end else if (phase_ff == PHASE_CRC_LOW) begin
                  phase_in = PHASE_IDLE;
                  lane[0].packet_byte   = crc_ff[7:0];
                  lane[0].end_of_packet = 1'b1;
                  push_n = 2'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign qcount_in = qcount_ff + {1'b0, push_n} - {{(ympf_pkg::QCNT_W-1){1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= 16'h0000;
         count_ff  <= '0;
         phase_ff  <= PHASE_IDLE;
         large_ff  <= 1'b0;
         fill_ff   <= 8'h00;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcount_ff <= '0;
      end else begin
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         large_ff  <= large_in;
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + ympf_pkg::QPTR_W'(pop);
         qcount_ff <= qcount_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (2'(k) < push_n) begin
            queue_ff[wr_ptr_ff + ympf_pkg::QPTR_W'(k)] <= lane[k];
         end
      end
   end

   assign rsp.valid         = (qcount_ff != '0);
   assign rsp.packet_byte   = queue_ff[rd_ptr_ff].packet_byte;
   assign rsp.end_of_packet = queue_ff[rd_ptr_ff].end_of_packet;

   `YMPF_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, qcount_ff <= DEPTH_LIMIT)
   `YMPF_ASSERT_NEXT(a_start_enters_payload, clock, reset,
      accept && req.operation == ympf_pkg::OP_START,
      phase_ff == PHASE_PAYLOAD && count_ff == '0 && qcount_ff >= 3'd3)
   `YMPF_ASSERT_SAME(a_crc_low_after_full, clock, reset,
      phase_ff == PHASE_CRC_LOW, count_ff == cur_size)
   `YMPF_ASSERT_NEXT(a_data_advances_count, clock, reset,
      accept && req.operation == ympf_pkg::OP_DATA && phase_ff == PHASE_PAYLOAD && !full,
      count_ff == $past(count_ff) + CNT_W'(1))

endmodule

`default_nettype wire
